// ===== rtl/core/lpht_pkg.sv =====
// package for the linear probing hash table core
// shared constants, operation codes and memory access types; no dependencies
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int IDX_W      = 6;
  localparam int TABLE_SIZE = 1 << IDX_W;
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int KEY_W      = 31;
  localparam int KIND_W     = 2;
  localparam int PROBE_W    = 7;

  localparam logic [KIND_W-1:0] OP_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [KIND_W-1:0] OP_NOP    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_PROBE = 2'b10
  } state_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic             wr_used;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_key;
  } mem_req_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
  } mem_rsp_t;

endpackage

// ===== rtl/core/lpht_if.sv =====
// request and result channel interfaces
// depends on lpht_pkg
`timescale 1ns / 1ps

interface lpht_req_if;
  logic                         valid;
  logic                         ready;
  logic [lpht_pkg::KIND_W-1:0] kind;
  logic [lpht_pkg::KEY_W-1:0]  key_value;

  modport source (output valid, kind, key_value, input ready);
  modport sink   (input valid, kind, key_value, output ready);
endinterface

interface lpht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lpht_pkg::PROBE_W-1:0] probe_count;
  logic                          success;

  modport source (output valid, probe_count, success, input ready);
  modport sink   (input valid, probe_count, success, output ready);
endinterface

// ===== rtl/core/lpht_slot_mem.sv =====
// slot store: key memory with a registered read plus per-slot used flags
// depends on lpht_pkg
`timescale 1ns / 1ps

module lpht_slot_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  lpht_pkg::mem_req_t req,
  output lpht_pkg::mem_rsp_t rsp
);

  logic [lpht_pkg::KEY_W-1:0] key_mem [lpht_pkg::TABLE_SIZE];
  logic [lpht_pkg::TABLE_SIZE-1:0] used_r;
  logic [lpht_pkg::KEY_W-1:0] rd_key_r;
  logic used_rd_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      key_mem[req.wr_addr] <= req.wr_key;
    end
    if (req.rd_en) begin
      rd_key_r <= key_mem[req.rd_addr];
    end
  end

  // used flags clear at reset so the store starts empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      used_rd_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        used_r[req.wr_addr] <= req.wr_used;
      end
      if (req.rd_en) begin
        used_rd_r <= used_r[req.rd_addr];
      end
    end
  end

  assign rsp.used = used_rd_r;
  assign rsp.key  = rd_key_r;

endmodule

// ===== rtl/core/lpht_probe_ctrl.sv =====
// probe sequencer: walks slots one per cycle, commits the update, holds the result
// depends on lpht_pkg and lpht_if
`timescale 1ns / 1ps

module lpht_probe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  lpht_req_if.sink           in_req,
  lpht_rsp_if.source         out_rsp,
  output lpht_pkg::mem_req_t mem_req,
  input  lpht_pkg::mem_rsp_t mem_rsp
);

  lpht_pkg::state_t state_r, state_nxt;
  logic [lpht_pkg::KIND_W-1:0]  op_r, op_nxt;
  logic [lpht_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [lpht_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [lpht_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [lpht_pkg::PROBE_W-1:0] count_r, count_nxt;
  logic                          ok_r, ok_nxt;

  logic                          accept;
  logic                          out_free;
  logic                          match;
  logic                          last;
  logic                          done;
  logic                          ok;
  logic                          fire;
  logic [lpht_pkg::CNT_W-1:0]   probes;
  logic [lpht_pkg::IDX_W-1:0]   idx_inc;

  assign in_req.ready = (state_r == lpht_pkg::ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  assign match   = mem_rsp.used && (mem_rsp.key == key_r);
  assign last    = (cnt_r == lpht_pkg::CNT_W'(lpht_pkg::TABLE_SIZE - 1));
  assign probes  = cnt_r + lpht_pkg::CNT_W'(1);
  assign idx_inc = idx_r + lpht_pkg::IDX_W'(1);

  always_comb begin
    done = 1'b1;
    ok   = 1'b0;
    case (op_r) inside
      lpht_pkg::OP_INSERT: begin
        done = !mem_rsp.used || last;
        ok   = !mem_rsp.used;
      end
      lpht_pkg::OP_SEARCH, lpht_pkg::OP_REMOVE: begin
        done = match || !mem_rsp.used || last;
        ok   = match;
      end
      default: begin
        done = 1'b1;
        ok   = 1'b0;
      end
    endcase
  end

  assign fire = (state_r == lpht_pkg::ST_PROBE) && done && out_free;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    count_nxt     = count_r;
    ok_nxt        = ok_r;

    mem_req         = '0;
    mem_req.wr_addr = idx_r;
    mem_req.wr_key  = key_r;

    unique case (state_r)
      lpht_pkg::ST_IDLE: begin
        mem_req.rd_addr = in_req.key_value[lpht_pkg::IDX_W-1:0];
        if (accept) begin
          mem_req.rd_en = 1'b1;
          op_nxt        = in_req.kind;
          key_nxt       = in_req.key_value;
          idx_nxt       = in_req.key_value[lpht_pkg::IDX_W-1:0];
          cnt_nxt       = '0;
          state_nxt     = lpht_pkg::ST_PROBE;
        end
      end
      lpht_pkg::ST_PROBE: begin
        mem_req.rd_en = 1'b1;
        if (!done) begin
          // read of the next slot overlaps the compare of this one
          mem_req.rd_addr = idx_inc;
          idx_nxt         = idx_inc;
          cnt_nxt         = probes;
        end else begin
          mem_req.rd_addr = idx_r;
          if (fire) begin
            out_valid_nxt = 1'b1;
            ok_nxt        = ok;
            count_nxt     = (op_r == lpht_pkg::OP_NOP) ? '0
                                                       : lpht_pkg::PROBE_W'(probes);
            state_nxt     = lpht_pkg::ST_IDLE;
            if (op_r == lpht_pkg::OP_INSERT && ok) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_used = 1'b1;
            end
            if (op_r == lpht_pkg::OP_REMOVE && ok) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_used = 1'b0;
            end
          end
        end
      end
      default: begin
        state_nxt = lpht_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpht_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    count_r <= count_nxt;
    ok_r    <= ok_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.probe_count = count_r;
  assign out_rsp.success     = ok_r;

endmodule

// ===== rtl/core/linear_probe_hash_table_core.sv =====
// Open-addressed hash table with linear probing over a 64-slot store. A
// request is taken in the idle state and then probes one slot per cycle
// through the single read port of the key memory, up to all 64 slots; the
// block takes no new request until the probe ends. The home slot is the low
// six bits of the key. Insert takes the first empty slot without a duplicate
// check; search and remove stop at the key or the first empty slot, and
// remove empties the slot outright. The store is empty right after reset. A
// finished result waits in an output register, and the next request is taken
// while it waits; a request finishing while the previous result is still
// untaken holds until that result leaves.
// depends on lpht_pkg, lpht_if, lpht_slot_mem and lpht_probe_ctrl
`timescale 1ns / 1ps

module linear_probe_hash_table_core (
  input  logic       clk,
  input  logic       rst_n,
  lpht_req_if.sink   in_req,
  lpht_rsp_if.source out_rsp
);

  lpht_pkg::mem_req_t mem_req;
  lpht_pkg::mem_rsp_t mem_rsp;

  lpht_probe_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .mem_req (mem_req),
    .mem_rsp (mem_rsp)
  );

  lpht_slot_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rsp   (mem_rsp)
  );

endmodule

// ===== verif/tb_linear_probe_hash_table_core.sv =====
// testbench for linear_probe_hash_table_core: insert, search and remove requests
// checked against a slot-level table model kept in the bench, with random stalls
// depends on lpht_pkg, lpht_if and the core rtl
`timescale 1ns / 1ps

module tb_linear_probe_hash_table_core;

  localparam int CYCLE_LIMIT  = 1200000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [lpht_pkg::PROBE_W-1:0] probe_count;
    logic                         success;
  } probe_result_t;

  logic clk;
  logic rst_n;

  lpht_req_if in_req ();
  lpht_rsp_if out_rsp ();

  linear_probe_hash_table_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  // table model state
  logic                       slot_used [lpht_pkg::TABLE_SIZE];
  logic [lpht_pkg::KEY_W-1:0] slot_key  [lpht_pkg::TABLE_SIZE];
  int                         live_count;

  probe_result_t pending_results[$];
  int            fail_count;
  int            request_count;
  int            result_count;
  int            cycle_count;
  bit            quiet_stretch;
  int            stall_left;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 400 == 0) begin
      quiet_stretch = ($urandom_range(0, 3) == 0);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    $display("error at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  // mostly short waits, a few long ones, none during quiet stretches
  function automatic int pick_delay();
    int r;
    if (quiet_stretch) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  // walks the probe sequence and updates the model table
  function automatic probe_result_t predict_request(
    input logic [lpht_pkg::KIND_W-1:0] op,
    input logic [lpht_pkg::KEY_W-1:0]  key
  );
    probe_result_t              res;
    logic [lpht_pkg::IDX_W-1:0] idx;
    int                         probes;
    int                         i;
    res = '0;
    if (op == lpht_pkg::OP_NOP) begin
      return res;
    end
    idx    = key[lpht_pkg::IDX_W-1:0];
    probes = 0;
    for (i = 0; i < lpht_pkg::TABLE_SIZE; i++) begin
      probes++;
      if (op == lpht_pkg::OP_INSERT) begin
        if (!slot_used[idx]) begin
          slot_used[idx] = 1'b1;
          slot_key[idx]  = key;
          live_count++;
          res.success = 1'b1;
          break;
        end
      end else begin
        if (slot_used[idx] && slot_key[idx] == key) begin
          if (op == lpht_pkg::OP_REMOVE) begin
            slot_used[idx] = 1'b0;
            slot_key[idx]  = '0;
            live_count--;
          end
          res.success = 1'b1;
          break;
        end
        if (!slot_used[idx]) begin
          break;
        end
      end
      idx = idx + 1'b1;
    end
    res.probe_count = probes[lpht_pkg::PROBE_W-1:0];
    return res;
  endfunction

  // a stored key is reachable when no empty slot lies between its home and it
  function automatic bit slot_reachable(input int s);
    int h;
    h = int'(slot_key[s][lpht_pkg::IDX_W-1:0]);
    while (h != s) begin
      if (!slot_used[h]) begin
        return 1'b0;
      end
      h = (h + 1) % lpht_pkg::TABLE_SIZE;
    end
    return 1'b1;
  endfunction

  function automatic logic [lpht_pkg::KEY_W-1:0] fresh_key(input int lo_home, input int span);
    logic [lpht_pkg::KEY_W-1:0] k;
    k = lpht_pkg::KEY_W'($urandom);
    if (span > 0) begin
      k[lpht_pkg::IDX_W-1:0] =
        lpht_pkg::IDX_W'((lo_home + $urandom_range(0, span - 1)) % lpht_pkg::TABLE_SIZE);
    end
    return k;
  endfunction

  // stored key, preferring one that a search can still reach
  function automatic logic [lpht_pkg::KEY_W-1:0] pick_live_key();
    int start;
    int s;
    int i;
    int fallback;
    start    = $urandom_range(0, lpht_pkg::TABLE_SIZE - 1);
    fallback = -1;
    for (i = 0; i < lpht_pkg::TABLE_SIZE; i++) begin
      s = (start + i) % lpht_pkg::TABLE_SIZE;
      if (slot_used[s]) begin
        if (slot_reachable(s)) begin
          return slot_key[s];
        end
        if (fallback < 0) begin
          fallback = s;
        end
      end
    end
    if (fallback >= 0) begin
      return slot_key[fallback];
    end
    return fresh_key(0, 0);
  endfunction

  task automatic send_request(input logic [lpht_pkg::KIND_W-1:0] op,
                              input logic [lpht_pkg::KEY_W-1:0]  key);
    int gap;
    gap = pick_delay();
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.kind      <= op;
    in_req.key_value <= key;
    do @(posedge clk); while (!in_req.ready);
    pending_results.push_back(predict_request(op, key));
    request_count++;
  endtask

  // result side stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_rsp.ready <= 1'b0;
      stall_left--;
    end else begin
      out_rsp.ready <= 1'b1;
      stall_left = pick_delay();
    end
  end

  always @(posedge clk) begin : check_results
    probe_result_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result with no request outstanding: probe_count %0d success %0d",
                               out_rsp.probe_count, out_rsp.success));
      end else begin
        want = pending_results.pop_front();
        if (out_rsp.probe_count !== want.probe_count) begin
          report_error($sformatf("result %0d probe_count got %0d want %0d",
                                 result_count, out_rsp.probe_count, want.probe_count));
        end
        if (out_rsp.success !== want.success) begin
          report_error($sformatf("result %0d success got %0d want %0d",
                                 result_count, out_rsp.success, want.success));
        end
      end
      result_count++;
    end
  end

  task automatic test_directed();
    // misses on the empty table
    send_request(lpht_pkg::OP_SEARCH, 31'd5);
    send_request(lpht_pkg::OP_REMOVE, 31'd5);
    // collisions on home 0 and wrap from the last slot
    send_request(lpht_pkg::OP_INSERT, 31'd0);
    send_request(lpht_pkg::OP_INSERT, 31'd64);
    send_request(lpht_pkg::OP_INSERT, 31'h7fff_ffff);
    send_request(lpht_pkg::OP_INSERT, 31'd127);
    send_request(lpht_pkg::OP_SEARCH, 31'd127);
    send_request(lpht_pkg::OP_SEARCH, 31'd128);
    // duplicate insert
    send_request(lpht_pkg::OP_INSERT, 31'd0);
    send_request(lpht_pkg::OP_SEARCH, 31'd0);
    // remove leaves a hole, later chain members become unreachable
    send_request(lpht_pkg::OP_REMOVE, 31'd0);
    send_request(lpht_pkg::OP_SEARCH, 31'd0);
    send_request(lpht_pkg::OP_SEARCH, 31'd64);
    send_request(lpht_pkg::OP_SEARCH, 31'd127);
    // unused kind
    send_request(lpht_pkg::OP_NOP, 31'h7fff_ffff);
    send_request(lpht_pkg::OP_NOP, 31'd0);
    send_request(lpht_pkg::OP_REMOVE, 31'h7fff_ffff);
    send_request(lpht_pkg::OP_INSERT, 31'h4000_0000);
    send_request(lpht_pkg::OP_SEARCH, 31'h4000_0000);
    send_request(lpht_pkg::OP_REMOVE, 31'h2aaa_aaaa);
  endtask

  // fill to full, hit the full-table cases, then drain it with a capped run of removals
  task automatic test_fill_and_drain(input int rounds);
    int r;
    int n;
    for (r = 0; r < rounds; r++) begin
      while (live_count < lpht_pkg::TABLE_SIZE) begin
        n = $urandom_range(0, 9);
        if (n == 0 && live_count > 0) begin
          send_request(lpht_pkg::OP_INSERT, pick_live_key());
        end else if (n < 5) begin
          send_request(lpht_pkg::OP_INSERT,
                       fresh_key($urandom_range(0, lpht_pkg::TABLE_SIZE - 1), 4));
        end else begin
          send_request(lpht_pkg::OP_INSERT, fresh_key(0, 0));
        end
      end
      repeat (4) send_request(lpht_pkg::OP_INSERT, fresh_key(0, 0));
      repeat (4) send_request(lpht_pkg::OP_SEARCH, fresh_key(0, 0));
      repeat (2) send_request(lpht_pkg::OP_REMOVE, fresh_key(0, 0));
      repeat (6) send_request(lpht_pkg::OP_SEARCH, pick_live_key());
      send_request(lpht_pkg::OP_NOP, fresh_key(0, 0));
      n = 0;
      while (live_count > 0 && n < 150) begin
        case ($urandom_range(0, 5))
          0: begin
            send_request(lpht_pkg::OP_SEARCH, pick_live_key());
          end
          1: begin
            send_request(lpht_pkg::OP_REMOVE, fresh_key(0, 0));
          end
          default: begin
            send_request(lpht_pkg::OP_REMOVE, pick_live_key());
          end
        endcase
        n++;
      end
    end
  endtask

  task automatic test_random_mix(input int count);
    int                          i;
    int                          r;
    int                          base;
    logic [lpht_pkg::KIND_W-1:0] op;
    logic [lpht_pkg::KEY_W-1:0]  key;
    base = 0;
    for (i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        base = $urandom_range(0, lpht_pkg::TABLE_SIZE - 1);
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        op = lpht_pkg::OP_INSERT;
      end else if (r < 70) begin
        op = lpht_pkg::OP_SEARCH;
      end else if (r < 95) begin
        op = lpht_pkg::OP_REMOVE;
      end else begin
        op = lpht_pkg::OP_NOP;
      end
      if (op == lpht_pkg::OP_INSERT && live_count > 56 && $urandom_range(0, 1) == 1) begin
        op = lpht_pkg::OP_REMOVE;
      end
      r = $urandom_range(0, 99);
      if (op == lpht_pkg::OP_INSERT) begin
        if (r < 15 && live_count > 0) begin
          key = pick_live_key();
        end else if (r < 60) begin
          key = fresh_key(base, 4);
        end else begin
          key = fresh_key(0, 0);
        end
      end else if (op == lpht_pkg::OP_NOP) begin
        key = fresh_key(0, 0);
      end else begin
        if (r < 70 && live_count > 0) begin
          key = pick_live_key();
        end else if (r < 85) begin
          key = fresh_key(base, 4);
        end else begin
          key = fresh_key(0, 0);
        end
      end
      send_request(op, key);
    end
  endtask

  // long chains around the wrap point
  task automatic test_clusters(input int count);
    int i;
    int r;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_request(lpht_pkg::OP_INSERT, fresh_key(lpht_pkg::TABLE_SIZE - 2, 4));
      end else if (r < 75) begin
        if ($urandom_range(0, 9) < 6) begin
          send_request(lpht_pkg::OP_SEARCH, pick_live_key());
        end else begin
          send_request(lpht_pkg::OP_SEARCH, fresh_key(lpht_pkg::TABLE_SIZE - 2, 4));
        end
      end else begin
        if ($urandom_range(0, 9) < 7) begin
          send_request(lpht_pkg::OP_REMOVE, pick_live_key());
        end else begin
          send_request(lpht_pkg::OP_REMOVE, fresh_key(lpht_pkg::TABLE_SIZE - 2, 4));
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < lpht_pkg::TABLE_SIZE; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
    end
    live_count       = 0;
    fail_count       = 0;
    request_count    = 0;
    result_count     = 0;
    cycle_count      = 0;
    quiet_stretch    = 1'b0;
    rst_n            <= 1'b0;
    in_req.valid     <= 1'b0;
    in_req.kind      <= lpht_pkg::OP_INSERT;
    in_req.key_value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drain(4);
    test_random_mix(700);
    test_clusters(450);

    in_req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lpht_pkg.sv
rtl/core/lpht_if.sv
rtl/core/lpht_slot_mem.sv
rtl/core/lpht_probe_ctrl.sv
rtl/core/linear_probe_hash_table_core.sv
verif/tb_linear_probe_hash_table_core.sv
